// ----- hw/rtl/fmfws_pkg.sv -----
// Shared types, codes and constants of the font-metric fix_word scaler.
`timescale 1ns / 1ps
`default_nettype none

package fmfws_pkg;

    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 27;
    localparam int SPEC_W     = 28;
    localparam int NORM_W     = 23;
    localparam int PROD_W     = 55;
    localparam int CNT_W      = 6;
    localparam int MUL_STEPS  = SPEC_W;
    localparam int CFG_IDX_W  = 1;

    // Divide by 1000 as a shift by three and a reciprocal multiplication by 1/125.
    localparam int DIVD_W      = 34;
    localparam int RECIP_W     = 35;
    localparam int RLO_W       = 18;
    localparam int RECIP_SHIFT = 41;

    localparam logic [WORD_W-1:0]        DESIGN_RESET = 32'd10485760;
    localparam logic signed [SPEC_W-1:0] USE_DESIGN   = -28'sd1000;
    localparam logic [SIZE_W-1:0]        UNITY_SP     = 27'd65536;
    localparam logic [RECIP_W-1:0]       RECIP_125    = 35'd17592186045;
    // 1000 * 2^27: this product and any larger one scale to an oversized font.
    localparam logic [PROD_W-1:0]        SCALED_LIMIT = 55'd134217728000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DESIGN_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AT_SPEC     = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_SIGN = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

    typedef enum logic [2:0] {
        SZ_START,
        SZ_MUL,
        SZ_DIV,
        SZ_QUOT,
        SZ_NORM,
        SZ_IDLE
    } size_state_t;

    // Everything the word pipeline needs to know about the current size.
    typedef struct packed {
        logic              invalid;
        logic [SIZE_W-1:0] size;
        logic [NORM_W-1:0] zn;
        logic [2:0]        shift;
        logic [WORD_W-1:0] alpha;
    } size_info_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fmfws_if.sv -----
// Channel interfaces of the fix_word scaler: configuration, word and result.
`timescale 1ns / 1ps
`default_nettype none

interface fmfws_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fmfws_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [fmfws_pkg::WORD_W-1:0]     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

interface fmfws_word_if;
    logic                         valid;
    logic                         ready;
    logic [fmfws_pkg::WORD_W-1:0] raw_word;
    logic                         slant_mode;

    modport source (output valid, output raw_word, output slant_mode, input ready);
    modport sink (input valid, input raw_word, input slant_mode, output ready);
endinterface

interface fmfws_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [fmfws_pkg::WORD_W-1:0] scaled_value;
    logic [fmfws_pkg::SIZE_W-1:0]        font_size;
    logic [1:0]                          status;

    modport source (output valid, output scaled_value, output font_size, output status,
                    input ready);
    modport sink (input valid, input scaled_value, input font_size, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fmfws_size_unit.sv -----
// Configuration registers and the serial unit that derives the effective font size.
`timescale 1ns / 1ps
`default_nettype none

module fmfws_size_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    fmfws_cfg_if.sink                    cfg,
    output fmfws_pkg::size_info_t        info,
    output logic                         busy
);

    localparam int PLO_W = fmfws_pkg::DIVD_W + fmfws_pkg::RLO_W;
    localparam int PHI_W = fmfws_pkg::DIVD_W + fmfws_pkg::RECIP_W - fmfws_pkg::RLO_W;
    localparam int SUM_W = fmfws_pkg::DIVD_W + fmfws_pkg::RECIP_W;

    fmfws_pkg::size_state_t              state_reg, state_next;
    logic [fmfws_pkg::WORD_W-1:0]        dsw_reg;
    logic signed [fmfws_pkg::SPEC_W-1:0] at_reg;
    logic [fmfws_pkg::PROD_W-1:0]        acc_reg, acc_next;
    logic [fmfws_pkg::SPEC_W-1:0]        mpl_reg, mpl_next;
    logic [PLO_W-1:0]                    plo_reg, plo_next;
    logic [PHI_W-1:0]                    phi_reg, phi_next;
    logic [fmfws_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                                bad_reg, bad_next;
    fmfws_pkg::size_info_t               info_reg, info_next;

    logic [fmfws_pkg::SIZE_W-1:0]        z0;
    logic                                bad_design;
    logic [fmfws_pkg::DIVD_W-1:0]        eighth;
    logic [SUM_W-1:0]                    recip_sum;
    logic [fmfws_pkg::SIZE_W-1:0]        z;
    logic [2:0]                          k;
    logic                                cfg_beat;

    assign cfg.ready = 1'b1;
    assign cfg_beat  = cfg.valid & cfg.ready;
    assign info      = info_reg;
    assign busy      = (state_reg != fmfws_pkg::SZ_IDLE);

    assign z0         = dsw_reg[30:4];
    assign bad_design = dsw_reg[31] | (z0 < fmfws_pkg::UNITY_SP);
    assign eighth     = acc_reg[fmfws_pkg::DIVD_W+2:3];
    assign recip_sum  = {phi_reg, fmfws_pkg::RLO_W'(0)} + SUM_W'(plo_reg);
    assign z          = acc_reg[fmfws_pkg::SIZE_W-1:0];

    always_comb
    begin
        if (z[26])
            k = 3'd4;
        else if (z[25])
            k = 3'd3;
        else if (z[24])
            k = 3'd2;
        else if (z[23])
            k = 3'd1;
        else
            k = 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsw_reg <= fmfws_pkg::DESIGN_RESET;
            at_reg  <= fmfws_pkg::USE_DESIGN;
        end
        else if (cfg_beat)
        begin
            unique case (cfg.reg_index)
                fmfws_pkg::REG_DESIGN_SIZE: dsw_reg <= cfg.data;
                fmfws_pkg::REG_AT_SPEC:     at_reg  <= cfg.data[fmfws_pkg::SPEC_W-1:0];
                default:                    dsw_reg <= dsw_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fmfws_pkg::SZ_START;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
            info_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
            info_reg  <= info_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mpl_reg <= mpl_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        mpl_next   = mpl_reg;
        plo_next   = plo_reg;
        phi_next   = phi_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        info_next  = info_reg;
        unique case (state_reg)
            fmfws_pkg::SZ_START:
            begin
                bad_next = bad_design;
                if (at_reg == fmfws_pkg::USE_DESIGN)
                begin
                    acc_next   = fmfws_pkg::PROD_W'(z0);
                    state_next = fmfws_pkg::SZ_NORM;
                end
                else if (!at_reg[fmfws_pkg::SPEC_W-1])
                begin
                    acc_next   = fmfws_pkg::PROD_W'(at_reg[fmfws_pkg::SIZE_W-1:0]);
                    state_next = fmfws_pkg::SZ_NORM;
                end
                else
                begin
                    acc_next   = '0;
                    mpl_next   = fmfws_pkg::SPEC_W'(-at_reg);
                    cnt_next   = fmfws_pkg::CNT_W'(fmfws_pkg::MUL_STEPS);
                    state_next = fmfws_pkg::SZ_MUL;
                end
            end
            fmfws_pkg::SZ_MUL:
            begin
                // Multiplier bits are taken most significant first.
                acc_next = {acc_reg[fmfws_pkg::PROD_W-2:0], 1'b0}
                         + (mpl_reg[fmfws_pkg::SPEC_W-1] ? fmfws_pkg::PROD_W'(z0)
                                                         : fmfws_pkg::PROD_W'(0));
                mpl_next = {mpl_reg[fmfws_pkg::SPEC_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == fmfws_pkg::CNT_W'(1))
                    state_next = fmfws_pkg::SZ_DIV;
            end
            fmfws_pkg::SZ_DIV:
            begin
                // Only products below 1000 * 2^27 need an exact quotient; the rest
                // are oversized. Those fit the reciprocal after the shift by three.
                bad_next   = bad_reg | (acc_reg >= fmfws_pkg::SCALED_LIMIT);
                plo_next   = PLO_W'(eighth)
                           * PLO_W'(fmfws_pkg::RECIP_125[fmfws_pkg::RLO_W-1:0]);
                phi_next   = PHI_W'(eighth)
                           * PHI_W'(fmfws_pkg::RECIP_125[fmfws_pkg::RECIP_W-1:
                                                         fmfws_pkg::RLO_W]);
                state_next = fmfws_pkg::SZ_QUOT;
            end
            fmfws_pkg::SZ_QUOT:
            begin
                acc_next   = fmfws_pkg::PROD_W'(recip_sum[SUM_W-1:fmfws_pkg::RECIP_SHIFT]);
                state_next = fmfws_pkg::SZ_NORM;
            end
            fmfws_pkg::SZ_NORM:
            begin
                info_next.invalid = bad_reg | (|acc_reg[fmfws_pkg::PROD_W-1:fmfws_pkg::SIZE_W]);
                info_next.size    = z;
                info_next.shift   = k;
                info_next.zn      = fmfws_pkg::NORM_W'(z >> k);
                info_next.alpha   = fmfws_pkg::WORD_W'(fmfws_pkg::NORM_W'(z >> k))
                                    << (4'd4 + 4'(k));
                state_next        = fmfws_pkg::SZ_IDLE;
            end
            fmfws_pkg::SZ_IDLE:
            begin
                state_next = fmfws_pkg::SZ_IDLE;
            end
            default:
            begin
                state_next = fmfws_pkg::SZ_START;
            end
        endcase
        // A new register value always restarts the size derivation.
        if (cfg_beat)
            state_next = fmfws_pkg::SZ_START;
    end

    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_beat |=> busy)
        else $error("size unit not busy after a configuration beat");

    a_norm_below: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (info_reg.size >> info_reg.shift)
                  < (fmfws_pkg::SIZE_W'(1) << fmfws_pkg::NORM_W))
        else $error("normalized size out of range");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> info_reg.shift <= 3'd4)
        else $error("normalization shift out of range");

endmodule

`default_nettype wire

// ----- hw/rtl/fmfws_datapath.sv -----
// Three-stage word pipeline: byte products, partial sums, final scaling and status.
`timescale 1ns / 1ps
`default_nettype none

module fmfws_datapath (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  fmfws_pkg::size_info_t        info,
    input  wire logic                    hold,
    fmfws_word_if.sink                   word,
    fmfws_result_if.source               result
);

    localparam int PW = fmfws_pkg::NORM_W + 8;

    // Stage 1: byte products.
    logic                          v1_reg;
    logic [fmfws_pkg::WORD_W-1:0]  w1_reg;
    logic                          s1_reg;
    logic [PW-1:0]                 dz1_reg, cz1_reg, bz1_reg;
    // Stage 2: low partial sum.
    logic                          v2_reg;
    logic [fmfws_pkg::WORD_W-1:0]  w2_reg;
    logic                          s2_reg;
    logic [fmfws_pkg::WORD_W-1:0]  t2_reg;
    logic [PW-1:0]                 bz2_reg;
    // Stage 3: output register.
    logic                          v3_reg;
    logic [fmfws_pkg::WORD_W-1:0]  val3_reg, val3_next;
    logic [fmfws_pkg::SIZE_W-1:0]  size3_reg, size3_next;
    logic [1:0]                    st3_reg, st3_next;

    logic rdy1, rdy2, rdy3;
    logic accept;
    logic [fmfws_pkg::WORD_W-1:0]  sum;
    logic [fmfws_pkg::WORD_W-1:0]  sw;
    logic [fmfws_pkg::WORD_W-1:0]  slanted;
    logic [7:0]                    a2;

    assign rdy3 = !v3_reg | result.ready;
    assign rdy2 = !v2_reg | rdy3;
    assign rdy1 = !v1_reg | rdy2;
    assign word.ready = rdy1 & !hold;
    assign accept = word.valid & word.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= accept;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            w1_reg  <= word.raw_word;
            s1_reg  <= word.slant_mode;
            dz1_reg <= PW'(word.raw_word[7:0])   * PW'(info.zn);
            cz1_reg <= PW'(word.raw_word[15:8])  * PW'(info.zn);
            bz1_reg <= PW'(word.raw_word[23:16]) * PW'(info.zn);
        end
        if (rdy2)
        begin
            w2_reg  <= w1_reg;
            s2_reg  <= s1_reg;
            t2_reg  <= fmfws_pkg::WORD_W'(dz1_reg >> 8) + fmfws_pkg::WORD_W'(cz1_reg);
            bz2_reg <= bz1_reg;
        end
        if (rdy3)
        begin
            val3_reg  <= val3_next;
            size3_reg <= size3_next;
            st3_reg   <= st3_next;
        end
    end

    assign a2      = w2_reg[31:24];
    assign sum     = fmfws_pkg::WORD_W'(t2_reg >> 8) + fmfws_pkg::WORD_W'(bz2_reg);
    // Dividing by beta is a right shift by four less the normalization shift.
    assign sw      = sum >> (3'd4 - info.shift);
    assign slanted = {{4{w2_reg[31]}}, w2_reg[31:4]};

    always_comb
    begin
        val3_next  = '0;
        size3_next = info.size;
        st3_next   = fmfws_pkg::STATUS_OK;
        if (info.invalid)
        begin
            size3_next = '0;
            st3_next   = fmfws_pkg::STATUS_BAD_SIZE;
        end
        else if (s2_reg)
            val3_next = slanted;
        else if (a2 == 8'd0)
            val3_next = sw;
        else if (a2 == 8'd255)
            val3_next = sw - info.alpha;
        else
            st3_next = fmfws_pkg::STATUS_BAD_SIGN;
    end

    assign result.valid        = v3_reg;
    assign result.scaled_value = val3_reg;
    assign result.font_size    = size3_reg;
    assign result.status       = st3_reg;

    a_bad_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && st3_reg == fmfws_pkg::STATUS_BAD_SIZE |-> val3_reg == '0 && size3_reg == '0)
        else $error("bad size result carries nonzero fields");

    a_bad_sign_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && st3_reg == fmfws_pkg::STATUS_BAD_SIGN |-> val3_reg == '0)
        else $error("bad sign result carries a nonzero value");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> st3_reg != 2'd3)
        else $error("undefined status code");

    a_no_accept_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hold |-> !accept)
        else $error("word accepted while size unit busy");

endmodule

`default_nettype wire

// ----- hw/rtl/font_metric_fix_word_scaler.sv -----
// Top level of the font-metric fix_word scaler.
// Usage:
//   cfg    - register writes; index 0 is the design size word, index 1 the at-size
//            spec. Every beat is taken at once (ready is always high). Write only
//            while no word is in flight.
//   word   - one fix_word plus slant flag per beat.
//   result - one scaled value, effective font size and status per word, in order.
// After reset and after every configuration beat the size unit derives the
// effective size; word.ready stays low meanwhile. When the size is given directly
// or is the design size, the unit goes from SZ_START straight to SZ_NORM; when a
// scale factor applies it runs 28 serial multiply steps, the reciprocal
// multiplication for the divide by 1000 (SZ_DIV, SZ_QUOT) and the normalization.
// The word pipeline has three register stages, and result.valid is the valid bit
// of the third, so each word passes stages 1, 2 and 3 before its result beat; one
// word per cycle is sustained while the receiver is ready, the size unit is idle
// and cfg.valid is low. When the receiver stalls, bubbles in the pipeline still
// fill, and then word.ready drops; no beat is lost or repeated. Reset empties the
// pipeline.
`timescale 1ns / 1ps
`default_nettype none

module font_metric_fix_word_scaler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fmfws_cfg_if.sink       cfg,
    fmfws_word_if.sink      word,
    fmfws_result_if.source  result
);

    fmfws_pkg::size_info_t info;
    logic                  busy;
    logic                  hold;

    fmfws_size_unit u_size (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .info  (info),
        .busy  (busy)
    );

    assign hold = busy | cfg.valid;

    fmfws_datapath u_path (
        .clk    (clk),
        .rst_n  (rst_n),
        .info   (info),
        .hold   (hold),
        .word   (word),
        .result (result)
    );

endmodule

`default_nettype wire
